// File: rtl/core/tse_pkg.sv
// ----------------------------------------------------------------------------
// TLS hello SNI extractor package
// Shared types and constants for the server name extractor.
// ----------------------------------------------------------------------------
package tse_pkg;

    localparam int unsigned RANDOM_BYTES = 32;
    localparam logic [15:0] SNI_EXT_TYPE = 16'd0;
    localparam logic [7:0]  SNI_HOST_NAME_TYPE = 8'd0;
    localparam logic [7:0]  CCS_BYTE = 8'd1;
    localparam logic [20:0] HS_TYPE_MASK = 21'h11F817;
    localparam logic [7:0]  CT_CCS = 8'd20;
    localparam logic [7:0]  CT_HANDSHAKE = 8'd22;
    localparam logic [7:0]  CT_LOW = 8'd20;
    localparam logic [7:0]  CT_HIGH = 8'd23;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'd1;
    localparam logic [7:0]  HS_SERVER_HELLO = 8'd2;
    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
    localparam logic [16:0] REC_HDR_BYTES = 17'd5;
    localparam logic [16:0] HS_HDR_BYTES = 17'd9;
    localparam int unsigned FIFO_DEPTH = 4;

    localparam logic [0:0] CFG_MIN_VERSION = 1'b0;
    localparam logic [0:0] CFG_MAX_VERSION = 1'b1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_CONTENT = 3'd1,
        ST_BAD_REC_VER = 3'd2,
        ST_TRUNCATED   = 3'd3,
        ST_BAD_HS_TYPE = 3'd4,
        ST_BAD_HS_VER  = 3'd5,
        ST_BAD_CCS     = 3'd6
    } t_status;

    typedef enum logic [4:0] {
        P_REC_CT, P_REC_VER, P_REC_LEN, P_HS_TYPE, P_HS_LEN, P_HS_VER,
        P_RANDOM, P_SID_LEN, P_SID, P_SRV_CS, P_CS_LEN, P_CS, P_COMP_LEN, P_COMP,
        P_EXT_LEN, P_EXT_TYPE, P_EXT_LEN2, P_EXT_BODY, P_LIST_LEN, P_LIST_TYPE,
        P_NAME_LEN, P_NAME, P_CCS, P_DONE
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [7:0]  name_byte;
        logic [7:0]  content_type;
        logic [15:0] record_version;
        logic [7:0]  handshake_type;
        logic [15:0] handshake_version;
        logic [15:0] cipher_suite;
        logic        domain_found;
        logic [15:0] name_length;
        logic [2:0]  status;
        logic        last_of_run;
    } t_result;

endpackage

// File: rtl/core/tse_in_if.sv
// ----------------------------------------------------------------------------
// Payload byte channel
// Valid/ready channel carrying one segment byte and its end mark.
// ----------------------------------------------------------------------------
interface tse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_payload;

    modport source (output valid, output data_byte, output end_of_payload, input ready);
    modport sink (input valid, input data_byte, input end_of_payload, output ready);
endinterface

// File: rtl/core/tse_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying host name bytes and segment summaries.
// ----------------------------------------------------------------------------
interface tse_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  name_byte;
    logic [7:0]  content_type;
    logic [15:0] record_version;
    logic [7:0]  handshake_type;
    logic [15:0] handshake_version;
    logic [15:0] cipher_suite;
    logic        domain_found;
    logic [15:0] name_length;
    logic [2:0]  status;
    logic        last_of_run;

    modport source (output valid, output kind, output name_byte, output content_type,
        output record_version, output handshake_type, output handshake_version,
        output cipher_suite, output domain_found, output name_length, output status,
        output last_of_run, input ready);
    modport sink (input valid, input kind, input name_byte, input content_type,
        input record_version, input handshake_type, input handshake_version,
        input cipher_suite, input domain_found, input name_length, input status,
        input last_of_run, output ready);
endinterface

// File: rtl/core/tls_hello_sni_extractor.sv
// ----------------------------------------------------------------------------
// TLS hello SNI extractor
// Parses one TLS segment a byte at a time and streams the server name.
// ----------------------------------------------------------------------------
// One payload byte is parsed per cycle; a byte is taken in every cycle while
// the four-entry result queue has room for two results. A host name byte gives
// one result, the byte marked as end of payload gives a summary (after the
// name byte it may also carry), and the parser then returns to its start.
// Results leave the queue one per cycle while the receiver is ready, so a slow
// receiver holds off the payload bytes once the queue fills.
module tls_hello_sni_extractor (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    tse_in_if.sink            i_in,
    tse_out_if.source         o_res
);

    localparam int unsigned PW = $clog2(tse_pkg::FIFO_DEPTH);

    logic [15:0]     r_min_ver, r_max_ver;
    tse_pkg::t_phase r_phase, n_phase;
    logic [15:0]     r_fc, n_fc;
    logic [16:0]     r_pc, n_pc;
    logic [7:0]      r_ct, n_ct;
    logic [15:0]     r_rv, n_rv;
    logic [15:0]     r_rs, n_rs;
    logic [7:0]      r_ht, n_ht;
    logic [23:0]     r_hs, n_hs;
    logic [15:0]     r_hv, n_hv;
    logic [15:0]     r_cs, n_cs;
    logic [15:0]     r_ext, n_ext;
    logic [15:0]     r_skip, n_skip;
    logic [15:0]     r_hl, n_hl;
    logic            r_hd, n_hd;
    logic [2:0]      r_err, n_err;
    logic            r_sni, n_sni;

    tse_pkg::t_result r_fifo [tse_pkg::FIFO_DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [PW:0]      r_cnt;

    logic            acc, pop;
    logic [7:0]      b;
    logic            wdone;
    logic [15:0]     fc1;
    logic            name_out;
    tse_pkg::t_status st;
    tse_pkg::t_result name_res, sum_res;

    function automatic logic ver_ok(input logic [15:0] v, input logic [15:0] lo,
                                    input logic [15:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    assign acc = i_in.valid && i_in.ready;
    assign pop = o_res.valid && o_res.ready;
    assign b   = i_in.data_byte;
    assign i_in.ready = (r_cnt <= (PW+1)'(tse_pkg::FIFO_DEPTH - 2));
    assign wdone = (r_fc != 16'd0);
    assign fc1 = r_fc + 16'd1;

    always_comb begin
        logic [15:0] wv;
        n_phase = r_phase; n_fc = r_fc; n_ct = r_ct; n_rv = r_rv; n_rs = r_rs;
        n_ht = r_ht; n_hs = r_hs; n_hv = r_hv; n_cs = r_cs; n_ext = r_ext;
        n_skip = r_skip; n_hl = r_hl; n_hd = r_hd; n_err = r_err; n_sni = r_sni;
        name_out = 1'b0;
        n_pc = (r_pc < tse_pkg::COUNT_MAX) ? r_pc + 17'd1 : r_pc;
        wv = 16'd0;
        if (r_phase >= tse_pkg::P_EXT_TYPE && r_phase <= tse_pkg::P_NAME && r_ext != 16'd0) begin
            n_ext = r_ext - 16'd1;
        end
        case (r_phase)
            tse_pkg::P_REC_CT: begin
                n_ct = b;
                if (b < tse_pkg::CT_LOW || b > tse_pkg::CT_HIGH) begin
                    n_err = tse_pkg::ST_BAD_CONTENT; n_phase = tse_pkg::P_DONE;
                end else begin
                    n_phase = tse_pkg::P_REC_VER;
                end
            end
            tse_pkg::P_REC_VER: begin
                wv = wdone ? {r_rv[7:0], b} : {8'd0, b};
                n_rv = wv; n_fc = wdone ? 16'd0 : fc1;
                if (wdone) begin
                    if (!ver_ok(wv, r_min_ver, r_max_ver)) begin
                        n_err = tse_pkg::ST_BAD_REC_VER; n_phase = tse_pkg::P_DONE;
                    end else begin
                        n_phase = tse_pkg::P_REC_LEN;
                    end
                end
            end
            tse_pkg::P_REC_LEN: begin
                n_rs = wdone ? {r_rs[7:0], b} : {8'd0, b};
                n_fc = wdone ? 16'd0 : fc1;
                if (wdone) begin
                    if (r_ct == tse_pkg::CT_HANDSHAKE) n_phase = tse_pkg::P_HS_TYPE;
                    else if (r_ct == tse_pkg::CT_CCS) n_phase = tse_pkg::P_CCS;
                    else n_phase = tse_pkg::P_DONE;
                end
            end
            tse_pkg::P_HS_TYPE: begin
                n_ht = b;
                if (b > 8'd20 || !tse_pkg::HS_TYPE_MASK[b[4:0]]) begin
                    n_err = tse_pkg::ST_BAD_HS_TYPE; n_phase = tse_pkg::P_DONE;
                end else begin
                    n_phase = tse_pkg::P_HS_LEN;
                end
            end
            tse_pkg::P_HS_LEN: begin
                n_hs = (r_fc == 16'd0) ? {16'd0, b} : {r_hs[15:0], b};
                if (fc1 >= 16'd3) begin
                    n_fc = 16'd0; n_phase = tse_pkg::P_HS_VER;
                end else begin
                    n_fc = fc1;
                end
            end
            tse_pkg::P_HS_VER: begin
                wv = wdone ? {r_hv[7:0], b} : {8'd0, b};
                n_hv = wv; n_fc = wdone ? 16'd0 : fc1;
                if (wdone) begin
                    if (!ver_ok(wv, r_min_ver, r_max_ver)) begin
                        n_err = tse_pkg::ST_BAD_HS_VER; n_phase = tse_pkg::P_DONE;
                    end else if (r_ht == tse_pkg::HS_CLIENT_HELLO ||
                                 r_ht == tse_pkg::HS_SERVER_HELLO) begin
                        n_skip = 16'(tse_pkg::RANDOM_BYTES); n_phase = tse_pkg::P_RANDOM;
                    end else begin
                        n_phase = tse_pkg::P_DONE;
                    end
                end
            end
            tse_pkg::P_RANDOM, tse_pkg::P_SID, tse_pkg::P_CS, tse_pkg::P_COMP,
            tse_pkg::P_EXT_BODY: begin
                n_skip = r_skip - 16'd1;
                if (n_skip == 16'd0) begin
                    case (r_phase)
                        tse_pkg::P_RANDOM: n_phase = tse_pkg::P_SID_LEN;
                        tse_pkg::P_SID: n_phase = (r_ht == tse_pkg::HS_SERVER_HELLO) ?
                            tse_pkg::P_SRV_CS : tse_pkg::P_CS_LEN;
                        tse_pkg::P_CS: n_phase = tse_pkg::P_COMP_LEN;
                        tse_pkg::P_COMP: n_phase = tse_pkg::P_EXT_LEN;
                        default: n_phase = (n_ext == 16'd0) ? tse_pkg::P_DONE :
                            tse_pkg::P_EXT_TYPE;
                    endcase
                end
            end
            tse_pkg::P_SID_LEN: begin
                n_skip = {8'd0, b};
                if (b != 8'd0) n_phase = tse_pkg::P_SID;
                else n_phase = (r_ht == tse_pkg::HS_SERVER_HELLO) ?
                    tse_pkg::P_SRV_CS : tse_pkg::P_CS_LEN;
            end
            tse_pkg::P_SRV_CS: begin
                wv = wdone ? {r_skip[7:0], b} : {8'd0, b};
                n_skip = wv; n_fc = wdone ? 16'd0 : fc1;
                if (wdone) begin
                    n_cs = wv; n_phase = tse_pkg::P_DONE;
                end
            end
            tse_pkg::P_CS_LEN: begin
                wv = wdone ? {r_skip[7:0], b} : {8'd0, b};
                n_skip = wv; n_fc = wdone ? 16'd0 : fc1;
                if (wdone) n_phase = (wv != 16'd0) ? tse_pkg::P_CS : tse_pkg::P_COMP_LEN;
            end
            tse_pkg::P_COMP_LEN: begin
                n_skip = {8'd0, b};
                n_phase = (b != 8'd0) ? tse_pkg::P_COMP : tse_pkg::P_EXT_LEN;
            end
            tse_pkg::P_EXT_LEN: begin
                wv = wdone ? {r_ext[7:0], b} : {8'd0, b};
                n_ext = wv; n_fc = wdone ? 16'd0 : fc1;
                if (wdone) n_phase = (wv == 16'd0) ? tse_pkg::P_DONE : tse_pkg::P_EXT_TYPE;
            end
            tse_pkg::P_EXT_TYPE: begin
                wv = wdone ? {r_skip[7:0], b} : {8'd0, b};
                n_skip = wv; n_fc = wdone ? 16'd0 : fc1;
                if (wdone) begin
                    n_sni = (wv == tse_pkg::SNI_EXT_TYPE); n_phase = tse_pkg::P_EXT_LEN2;
                end
            end
            tse_pkg::P_EXT_LEN2: begin
                wv = wdone ? {r_skip[7:0], b} : {8'd0, b};
                n_skip = wv; n_fc = wdone ? 16'd0 : fc1;
                if (wdone) begin
                    if (r_sni) n_phase = tse_pkg::P_LIST_LEN;
                    else if (wv != 16'd0) n_phase = tse_pkg::P_EXT_BODY;
                    else n_phase = (n_ext == 16'd0) ? tse_pkg::P_DONE : tse_pkg::P_EXT_TYPE;
                end
            end
            tse_pkg::P_LIST_LEN: begin
                wv = wdone ? {r_skip[7:0], b} : {8'd0, b};
                n_skip = wv; n_fc = wdone ? 16'd0 : fc1;
                if (wdone) n_phase = tse_pkg::P_LIST_TYPE;
            end
            tse_pkg::P_LIST_TYPE: begin
                n_phase = (b != tse_pkg::SNI_HOST_NAME_TYPE || r_skip == 16'd0) ?
                    tse_pkg::P_DONE : tse_pkg::P_NAME_LEN;
            end
            tse_pkg::P_NAME_LEN: begin
                wv = wdone ? {r_skip[7:0], b} : {8'd0, b};
                n_skip = wv; n_fc = wdone ? 16'd0 : fc1;
                if (wdone) begin
                    n_hl = wv;
                    n_phase = (wv == 16'd0) ? tse_pkg::P_DONE : tse_pkg::P_NAME;
                end
            end
            tse_pkg::P_NAME: begin
                name_out = 1'b1;
                if (fc1 >= r_hl) begin
                    n_fc = 16'd0; n_hd = 1'b1; n_phase = tse_pkg::P_DONE;
                end else begin
                    n_fc = fc1;
                end
            end
            tse_pkg::P_CCS: begin
                if (b != tse_pkg::CCS_BYTE) begin
                    n_err = tse_pkg::ST_BAD_CCS; n_phase = tse_pkg::P_DONE;
                end else begin
                    n_phase = tse_pkg::P_DONE;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        logic rec_short, hs_short;
        rec_short = (n_pc >= tse_pkg::REC_HDR_BYTES) &&
                    ((n_pc - tse_pkg::REC_HDR_BYTES) < {1'b0, n_rs});
        hs_short  = (n_pc >= tse_pkg::HS_HDR_BYTES) &&
                    ({7'd0, n_pc - tse_pkg::HS_HDR_BYTES} < n_hs);
        st = tse_pkg::ST_OK;
        if (n_err == tse_pkg::ST_BAD_CONTENT || n_err == tse_pkg::ST_BAD_REC_VER) begin
            st = tse_pkg::t_status'(n_err);
        end else if (n_phase <= tse_pkg::P_REC_LEN || rec_short) begin
            st = tse_pkg::ST_TRUNCATED;
        end else if (n_ct == tse_pkg::CT_HANDSHAKE) begin
            if (n_err == tse_pkg::ST_BAD_HS_TYPE) st = tse_pkg::ST_BAD_HS_TYPE;
            else if (n_phase == tse_pkg::P_HS_TYPE || n_phase == tse_pkg::P_HS_LEN ||
                     hs_short) st = tse_pkg::ST_TRUNCATED;
            else if (n_err == tse_pkg::ST_BAD_HS_VER) st = tse_pkg::ST_BAD_HS_VER;
            else if (n_phase == tse_pkg::P_HS_VER) st = tse_pkg::ST_TRUNCATED;
        end else if (n_ct == tse_pkg::CT_CCS) begin
            if (n_err == tse_pkg::ST_BAD_CCS || n_phase == tse_pkg::P_CCS) begin
                st = tse_pkg::ST_BAD_CCS;
            end
        end

        name_res = '0;
        name_res.name_byte = b;
        name_res.last_of_run = !i_in.end_of_payload;

        sum_res = '0;
        sum_res.kind = 1'b1;
        sum_res.content_type = n_ct;
        sum_res.record_version = n_rv;
        sum_res.handshake_type = n_ht;
        sum_res.handshake_version = n_hv;
        sum_res.cipher_suite = n_cs;
        sum_res.domain_found = n_hd;
        sum_res.name_length = n_hl;
        sum_res.status = st;
        sum_res.last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        logic [PW:0]   pushes;
        logic [PW-1:0] wp;
        pushes = (PW+1)'(acc && name_out) + (PW+1)'(acc && i_in.end_of_payload);
        wp = r_wr;
        if (acc && name_out) begin
            r_fifo[wp] <= name_res;
            wp = wp + PW'(1);
        end
        if (acc && i_in.end_of_payload) begin
            r_fifo[wp] <= sum_res;
            wp = wp + PW'(1);
        end
        if (!i_rst_n) begin
            r_min_ver <= 16'd768; r_max_ver <= 16'd772;
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tse_pkg::CFG_MIN_VERSION: r_min_ver <= i_cfg_data;
                    tse_pkg::CFG_MAX_VERSION: r_max_ver <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_wr <= wp;
            if (pop) r_rd <= r_rd + PW'(1);
            r_cnt <= r_cnt + pushes - (PW+1)'(pop);
        end
        if (!i_rst_n || (acc && i_in.end_of_payload)) begin
            r_phase <= tse_pkg::P_REC_CT; r_fc <= '0; r_pc <= '0; r_ct <= '0;
            r_rv <= '0; r_rs <= '0; r_ht <= '0; r_hs <= '0; r_hv <= '0; r_cs <= '0;
            r_ext <= '0; r_skip <= '0; r_hl <= '0; r_hd <= 1'b0; r_err <= '0;
            r_sni <= 1'b0;
        end else if (acc) begin
            r_phase <= n_phase; r_fc <= n_fc; r_pc <= n_pc; r_ct <= n_ct;
            r_rv <= n_rv; r_rs <= n_rs; r_ht <= n_ht; r_hs <= n_hs; r_hv <= n_hv;
            r_cs <= n_cs; r_ext <= n_ext; r_skip <= n_skip; r_hl <= n_hl;
            r_hd <= n_hd; r_err <= n_err; r_sni <= n_sni;
        end
    end

    assign o_res.valid             = (r_cnt != '0);
    assign o_res.kind              = r_fifo[r_rd].kind;
    assign o_res.name_byte         = r_fifo[r_rd].name_byte;
    assign o_res.content_type      = r_fifo[r_rd].content_type;
    assign o_res.record_version    = r_fifo[r_rd].record_version;
    assign o_res.handshake_type    = r_fifo[r_rd].handshake_type;
    assign o_res.handshake_version = r_fifo[r_rd].handshake_version;
    assign o_res.cipher_suite      = r_fifo[r_rd].cipher_suite;
    assign o_res.domain_found      = r_fifo[r_rd].domain_found;
    assign o_res.name_length       = r_fifo[r_rd].name_length;
    assign o_res.status            = r_fifo[r_rd].status;
    assign o_res.last_of_run       = r_fifo[r_rd].last_of_run;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(tse_pkg::FIFO_DEPTH))
        else $error("result queue overflow");
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_in.end_of_payload |=> r_phase == tse_pkg::P_REC_CT && r_pc == '0)
        else $error("parser not cleared after end of payload");
    a_host_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hd |-> r_phase == tse_pkg::P_DONE)
        else $error("host name done outside done phase");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PW'(r_wr - r_rd) == r_cnt[PW-1:0])
        else $error("queue pointers disagree with count");
`endif

endmodule

// File: tb/tse_result_checker.sv
// ----------------------------------------------------------------------------
// SNI extractor result checker
// Watches the byte and result channels, predicts each result from the
// accepted bytes and compares it with what the extractor returns.
// ----------------------------------------------------------------------------
module tse_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    tse_in_if           i_in,
    tse_out_if          i_res,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0]     ver_lo, ver_hi;
    tse_pkg::t_phase ph;
    logic [15:0]     fcnt;
    logic [16:0]     nbytes;
    logic [7:0]      ct;
    logic [15:0]     rec_ver, rec_size;
    logic [7:0]      hs_type;
    logic [23:0]     hs_size;
    logic [15:0]     hs_ver, cipher, ext_left, skip, host_len;
    logic            host_done, ext_sni;
    logic [2:0]      err;

    tse_pkg::t_result expected_results[$];

    function automatic logic ver_in_window(logic [15:0] v);
        return v >= ver_lo && v <= ver_hi;
    endfunction

    task automatic clear_parser();
        ph = tse_pkg::P_REC_CT; fcnt = 0; nbytes = 0; ct = 0; rec_ver = 0; rec_size = 0;
        hs_type = 0; hs_size = 0; hs_ver = 0; cipher = 0; ext_left = 0; skip = 0;
        host_len = 0; host_done = 0; err = 0; ext_sni = 0;
    endtask

    task automatic shift_word(inout logic [15:0] w, input logic [7:0] b,
                              input int n, output logic full);
        w = (fcnt == 0) ? {8'd0, b} : {w[7:0], b};
        fcnt++;
        full = fcnt >= n;
        if (full) fcnt = 0;
    endtask

    task automatic bad(logic [2:0] code);
        err = code;
        ph = tse_pkg::P_DONE;
    endtask

    task automatic walk_next_ext();
        ph = (ext_left == 0) ? tse_pkg::P_DONE : tse_pkg::P_EXT_TYPE;
    endtask

    function automatic logic [2:0] segment_status();
        if (err == tse_pkg::ST_BAD_CONTENT || err == tse_pkg::ST_BAD_REC_VER) return err;
        if (ph <= tse_pkg::P_REC_LEN) return tse_pkg::ST_TRUNCATED;
        if (17'(nbytes - 17'd5) < {1'b0, rec_size}) return tse_pkg::ST_TRUNCATED;
        if (ct == tse_pkg::CT_HANDSHAKE) begin
            if (err == tse_pkg::ST_BAD_HS_TYPE) return tse_pkg::ST_BAD_HS_TYPE;
            if (ph == tse_pkg::P_HS_TYPE || ph == tse_pkg::P_HS_LEN)
                return tse_pkg::ST_TRUNCATED;
            if (32'(17'(nbytes - 17'd9)) < 32'(hs_size)) return tse_pkg::ST_TRUNCATED;
            if (err == tse_pkg::ST_BAD_HS_VER) return tse_pkg::ST_BAD_HS_VER;
            if (ph == tse_pkg::P_HS_VER) return tse_pkg::ST_TRUNCATED;
            return tse_pkg::ST_OK;
        end
        if (ct == tse_pkg::CT_CCS && (err == tse_pkg::ST_BAD_CCS || ph == tse_pkg::P_CCS))
            return tse_pkg::ST_BAD_CCS;
        return tse_pkg::ST_OK;
    endfunction

    task automatic parse_beat(logic [7:0] b, logic eop);
        logic             full;
        tse_pkg::t_result r;
        r = '0;
        if (nbytes != tse_pkg::COUNT_MAX) nbytes++;
        if (ph >= tse_pkg::P_EXT_TYPE && ph <= tse_pkg::P_NAME && ext_left > 0) ext_left--;
        case (ph)
            tse_pkg::P_REC_CT: begin
                ct = b;
                if (b < tse_pkg::CT_LOW || b > tse_pkg::CT_HIGH) bad(tse_pkg::ST_BAD_CONTENT);
                else ph = tse_pkg::P_REC_VER;
            end
            tse_pkg::P_REC_VER: begin
                shift_word(rec_ver, b, 2, full);
                if (full) begin
                    if (!ver_in_window(rec_ver)) bad(tse_pkg::ST_BAD_REC_VER);
                    else ph = tse_pkg::P_REC_LEN;
                end
            end
            tse_pkg::P_REC_LEN: begin
                shift_word(rec_size, b, 2, full);
                if (full) ph = (ct == tse_pkg::CT_HANDSHAKE) ? tse_pkg::P_HS_TYPE
                             : (ct == tse_pkg::CT_CCS) ? tse_pkg::P_CCS : tse_pkg::P_DONE;
            end
            tse_pkg::P_HS_TYPE: begin
                hs_type = b;
                if (b > 20 || !tse_pkg::HS_TYPE_MASK[b[4:0]]) bad(tse_pkg::ST_BAD_HS_TYPE);
                else ph = tse_pkg::P_HS_LEN;
            end
            tse_pkg::P_HS_LEN: begin
                hs_size = (fcnt == 0) ? {16'd0, b} : {hs_size[15:0], b};
                fcnt++;
                if (fcnt >= 3) begin
                    fcnt = 0;
                    ph = tse_pkg::P_HS_VER;
                end
            end
            tse_pkg::P_HS_VER: begin
                shift_word(hs_ver, b, 2, full);
                if (full) begin
                    if (!ver_in_window(hs_ver)) bad(tse_pkg::ST_BAD_HS_VER);
                    else if (hs_type == tse_pkg::HS_CLIENT_HELLO ||
                             hs_type == tse_pkg::HS_SERVER_HELLO) begin
                        skip = 16'(tse_pkg::RANDOM_BYTES);
                        ph = tse_pkg::P_RANDOM;
                    end else ph = tse_pkg::P_DONE;
                end
            end
            tse_pkg::P_RANDOM, tse_pkg::P_SID, tse_pkg::P_CS, tse_pkg::P_COMP,
            tse_pkg::P_EXT_BODY: begin
                skip--;
                if (skip == 0) begin
                    case (ph)
                        tse_pkg::P_RANDOM: ph = tse_pkg::P_SID_LEN;
                        tse_pkg::P_SID:    ph = (hs_type == tse_pkg::HS_SERVER_HELLO) ?
                                                tse_pkg::P_SRV_CS : tse_pkg::P_CS_LEN;
                        tse_pkg::P_CS:     ph = tse_pkg::P_COMP_LEN;
                        tse_pkg::P_COMP:   ph = tse_pkg::P_EXT_LEN;
                        default:           walk_next_ext();
                    endcase
                end
            end
            tse_pkg::P_SID_LEN: begin
                skip = {8'd0, b};
                if (b != 0) ph = tse_pkg::P_SID;
                else ph = (hs_type == tse_pkg::HS_SERVER_HELLO) ?
                          tse_pkg::P_SRV_CS : tse_pkg::P_CS_LEN;
            end
            tse_pkg::P_SRV_CS: begin
                shift_word(skip, b, 2, full);
                if (full) begin
                    cipher = skip;
                    ph = tse_pkg::P_DONE;
                end
            end
            tse_pkg::P_CS_LEN: begin
                shift_word(skip, b, 2, full);
                if (full) ph = (skip != 0) ? tse_pkg::P_CS : tse_pkg::P_COMP_LEN;
            end
            tse_pkg::P_COMP_LEN: begin
                skip = {8'd0, b};
                ph = (b != 0) ? tse_pkg::P_COMP : tse_pkg::P_EXT_LEN;
            end
            tse_pkg::P_EXT_LEN: begin
                shift_word(ext_left, b, 2, full);
                if (full) walk_next_ext();
            end
            tse_pkg::P_EXT_TYPE: begin
                shift_word(skip, b, 2, full);
                if (full) begin
                    ext_sni = skip == tse_pkg::SNI_EXT_TYPE;
                    ph = tse_pkg::P_EXT_LEN2;
                end
            end
            tse_pkg::P_EXT_LEN2: begin
                shift_word(skip, b, 2, full);
                if (full) begin
                    if (ext_sni) ph = tse_pkg::P_LIST_LEN;
                    else if (skip != 0) ph = tse_pkg::P_EXT_BODY;
                    else walk_next_ext();
                end
            end
            tse_pkg::P_LIST_LEN: begin
                shift_word(skip, b, 2, full);
                if (full) ph = tse_pkg::P_LIST_TYPE;
            end
            tse_pkg::P_LIST_TYPE:
                ph = (b != tse_pkg::SNI_HOST_NAME_TYPE || skip == 0) ?
                     tse_pkg::P_DONE : tse_pkg::P_NAME_LEN;
            tse_pkg::P_NAME_LEN: begin
                shift_word(skip, b, 2, full);
                if (full) begin
                    host_len = skip;
                    ph = (skip == 0) ? tse_pkg::P_DONE : tse_pkg::P_NAME;
                end
            end
            tse_pkg::P_NAME: begin
                r.name_byte = b;
                r.last_of_run = !eop;
                expected_results.push_back(r);
                fcnt++;
                if (fcnt >= host_len) begin
                    fcnt = 0;
                    host_done = 1;
                    ph = tse_pkg::P_DONE;
                end
            end
            tse_pkg::P_CCS: begin
                if (b != tse_pkg::CCS_BYTE) bad(tse_pkg::ST_BAD_CCS);
                else ph = tse_pkg::P_DONE;
            end
            default: ;
        endcase
        if (eop) begin
            r = '0;
            r.kind = 1;
            r.content_type = ct;
            r.record_version = rec_ver;
            r.handshake_type = hs_type;
            r.handshake_version = hs_ver;
            r.cipher_suite = cipher;
            r.domain_found = host_done;
            r.name_length = host_len;
            r.status = segment_status();
            r.last_of_run = 1;
            expected_results.push_back(r);
            clear_parser();
        end
    endtask

    task automatic compare_result();
        tse_pkg::t_result e;
        if (expected_results.size() == 0) begin
            $error("unexpected result beat kind=%0d", i_res.kind);
            o_fail_count++;
            return;
        end
        e = expected_results.pop_front();
        if (i_res.kind !== e.kind) begin
            $error("kind exp %0h got %0h", e.kind, i_res.kind); o_fail_count++; end
        if (i_res.name_byte !== e.name_byte) begin
            $error("name_byte exp %0h got %0h", e.name_byte, i_res.name_byte);
            o_fail_count++; end
        if (i_res.content_type !== e.content_type) begin
            $error("content_type exp %0h got %0h", e.content_type, i_res.content_type);
            o_fail_count++; end
        if (i_res.record_version !== e.record_version) begin
            $error("record_version exp %0h got %0h", e.record_version,
                   i_res.record_version); o_fail_count++; end
        if (i_res.handshake_type !== e.handshake_type) begin
            $error("handshake_type exp %0h got %0h", e.handshake_type,
                   i_res.handshake_type); o_fail_count++; end
        if (i_res.handshake_version !== e.handshake_version) begin
            $error("handshake_version exp %0h got %0h", e.handshake_version,
                   i_res.handshake_version); o_fail_count++; end
        if (i_res.cipher_suite !== e.cipher_suite) begin
            $error("cipher_suite exp %0h got %0h", e.cipher_suite, i_res.cipher_suite);
            o_fail_count++; end
        if (i_res.domain_found !== e.domain_found) begin
            $error("domain_found exp %0h got %0h", e.domain_found, i_res.domain_found);
            o_fail_count++; end
        if (i_res.name_length !== e.name_length) begin
            $error("name_length exp %0h got %0h", e.name_length, i_res.name_length);
            o_fail_count++; end
        if (i_res.status !== e.status) begin
            $error("status exp %0h got %0h", e.status, i_res.status); o_fail_count++; end
        if (i_res.last_of_run !== e.last_of_run) begin
            $error("last_of_run exp %0h got %0h", e.last_of_run, i_res.last_of_run);
            o_fail_count++; end
    endtask

    initial o_fail_count = 0;
    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ver_lo <= 16'd768;
            ver_hi <= 16'd772;
            clear_parser();
            expected_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) compare_result();
            if (i_in.valid && i_in.ready) parse_beat(i_in.data_byte, i_in.end_of_payload);
            if (i_cfg_we) begin
                if (i_cfg_idx == tse_pkg::CFG_MIN_VERSION) ver_lo <= i_cfg_data;
                else ver_hi <= i_cfg_data;
            end
        end
    end
endmodule

// File: tb/tls_hello_sni_extractor_test.sv
// ----------------------------------------------------------------------------
// SNI extractor testbench
// Drives TLS segments (client and server hellos, change cipher spec, broken
// and truncated records, noise) under several version windows with random
// sender gaps and receiver stalls; the checker predicts every result.
// ----------------------------------------------------------------------------
module tls_hello_sni_extractor_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    int          fail_count;
    int          pending;
    int          beats_sent;
    logic        hold_off;

    tse_in_if  in_ch();
    tse_out_if res_ch();

    tls_hello_sni_extractor u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in(in_ch.sink), .o_res(res_ch.source)
    );

    tse_result_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in(in_ch), .i_res(res_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tls_hello_sni_extractor_test: FAIL");
        $finish;
    end

    // receiver: stall pattern plus one long hold-off
    initial begin
        int mode;
        res_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off) res_ch.ready <= 0;
            else begin
                mode = (beats_sent / 150) % 3;
                if (mode == 0) res_ch.ready <= 1;
                else if (mode == 1) res_ch.ready <= ($urandom_range(0, 3) != 0);
                else res_ch.ready <= ($urandom_range(0, 2) == 0);
            end
        end
    end

    initial begin
        hold_off = 0;
        wait (beats_sent >= 60);
        hold_off = 1;
        repeat (200) @(posedge i_clk);
        hold_off = 0;
    end

    logic [7:0] seg[$];
    int burst_left;

    task automatic send_beat(logic [7:0] b, logic eop);
        if (burst_left == 0) begin
            in_ch.valid <= 0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        in_ch.valid <= 1;
        in_ch.data_byte <= b;
        in_ch.end_of_payload <= eop;
        do @(posedge i_clk); while (!in_ch.ready);
        beats_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_segment(int cut);
        int n;
        n = (cut >= 0 && cut < seg.size()) ? cut : seg.size();
        if (n == 0) n = 1;
        for (int i = 0; i < n; i++)
            send_beat(i < seg.size() ? seg[i] : 8'($urandom), i == n - 1);
        seg.delete();
    endtask

    task automatic put16(logic [15:0] v);
        seg.push_back(v[15:8]);
        seg.push_back(v[7:0]);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] v);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    // hello with optional server name; sizes kept small
    task automatic build_hello(logic [7:0] hst, logic [15:0] ver, int name_len,
                               logic [7:0] list_type, bit other_ext);
        int sid, ncs, ncomp, ext_len;
        sid = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 4);
        ncs = $urandom_range(0, 3) == 0 ? 0 : 2 * $urandom_range(1, 3);
        ncomp = $urandom_range(0, 2);
        ext_len = (other_ext ? 6 : 0) + (name_len >= 0 ? 9 + name_len : 0);
        seg.push_back(tse_pkg::CT_HANDSHAKE);
        put16(ver);
        put16(16'($urandom_range(0, 300)));
        seg.push_back(hst);
        seg.push_back(0);
        put16(16'($urandom_range(0, 200)));
        put16(ver);
        repeat (tse_pkg::RANDOM_BYTES) seg.push_back(8'($urandom));
        seg.push_back(8'(sid));
        repeat (sid) seg.push_back(8'($urandom));
        if (hst == tse_pkg::HS_SERVER_HELLO) begin
            put16(16'($urandom));
            return;
        end
        put16(16'(ncs));
        repeat (ncs) seg.push_back(8'($urandom));
        seg.push_back(8'(ncomp));
        repeat (ncomp) seg.push_back(8'($urandom));
        put16(16'(ext_len));
        if (other_ext) begin
            put16(16'($urandom_range(1, 65535)));
            put16(2);
            put16(16'($urandom));
        end
        if (name_len >= 0) begin
            put16(tse_pkg::SNI_EXT_TYPE);
            put16(16'(5 + name_len));
            put16(16'(3 + name_len));
            seg.push_back(list_type);
            put16(16'(name_len));
            repeat (name_len) seg.push_back(8'($urandom));
        end
    endtask

    task automatic random_segment();
        int k;
        k = $urandom_range(0, 9);
        if (k <= 4)
            build_hello(tse_pkg::HS_CLIENT_HELLO, 16'($urandom_range(768, 772)),
                        $urandom_range(0, 7) == 0 ? -1 : $urandom_range(0, 12),
                        $urandom_range(0, 7) == 0 ? 8'($urandom) :
                            tse_pkg::SNI_HOST_NAME_TYPE,
                        $urandom_range(0, 1));
        else if (k == 5)
            build_hello(tse_pkg::HS_SERVER_HELLO, 16'($urandom_range(766, 774)), -1, 0, 0);
        else if (k == 6) begin
            seg.push_back(tse_pkg::CT_CCS); put16(16'($urandom_range(767, 773))); put16(1);
            seg.push_back($urandom_range(0, 1) ? tse_pkg::CCS_BYTE : 8'($urandom));
        end else if (k == 7) begin
            seg.push_back(tse_pkg::CT_HANDSHAKE); put16(16'd771);
            put16(16'($urandom_range(0, 20)));
            repeat ($urandom_range(1, 10)) seg.push_back(8'($urandom_range(0, 24)));
        end else
            repeat ($urandom_range(1, 8)) seg.push_back(8'($urandom));
        send_segment($urandom_range(0, 5) == 0 ? $urandom_range(1, seg.size()) : -1);
    endtask

    initial begin
        beats_sent = 0;
        burst_left = 0;
        i_rst_n = 0;
        i_cfg_we = 0; i_cfg_idx = tse_pkg::CFG_MIN_VERSION; i_cfg_data = 0;
        in_ch.valid = 0; in_ch.data_byte = 0; in_ch.end_of_payload = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed: bad content, ccs, truncation, hellos, full-range bytes
        seg.push_back(8'd19); send_segment(-1);
        seg.push_back(8'd255); seg.push_back(8'd0); send_segment(-1);
        seg.push_back(tse_pkg::CT_CCS); put16(16'd771); put16(1);
        seg.push_back(tse_pkg::CCS_BYTE);
        send_segment(-1);
        seg.push_back(tse_pkg::CT_CCS); put16(16'd771); put16(1); send_segment(-1);
        seg.push_back(8'd23); put16(16'd65535); send_segment(-1);
        build_hello(tse_pkg::HS_CLIENT_HELLO, 16'd771, 4, tse_pkg::SNI_HOST_NAME_TYPE, 1);
        send_segment(-1);
        build_hello(tse_pkg::HS_CLIENT_HELLO, 16'd772, 0, tse_pkg::SNI_HOST_NAME_TYPE, 0);
        send_segment(-1);
        build_hello(tse_pkg::HS_CLIENT_HELLO, 16'd768, 3, 8'd1, 0); send_segment(-1);
        build_hello(tse_pkg::HS_SERVER_HELLO, 16'd771, -1, 0, 0); send_segment(-1);
        seg.push_back(tse_pkg::CT_HANDSHAKE); put16(16'd771); put16(4); seg.push_back(8'd3);
        send_segment(-1);
        drain();

        write_reg(tse_pkg::CFG_MIN_VERSION, 16'd0);
        write_reg(tse_pkg::CFG_MAX_VERSION, 16'd65535);
        repeat (2) random_segment();
        drain();
        write_reg(tse_pkg::CFG_MIN_VERSION, 16'd771);
        write_reg(tse_pkg::CFG_MAX_VERSION, 16'd769);
        repeat (1) random_segment();
        drain();
        write_reg(tse_pkg::CFG_MIN_VERSION, 16'd768);
        write_reg(tse_pkg::CFG_MAX_VERSION, 16'd772);
        repeat (1) random_segment();
        drain();
        repeat (50) @(negedge i_clk);

        if (fail_count == 0) $display("tls_hello_sni_extractor_test: PASS");
        else $display("tls_hello_sni_extractor_test: FAIL");
        $finish;
    end
endmodule

// File: filelist.f
rtl/core/tse_pkg.sv
rtl/core/tse_in_if.sv
rtl/core/tse_out_if.sv
rtl/core/tls_hello_sni_extractor.sv
tb/tse_result_checker.sv
tb/tls_hello_sni_extractor_test.sv
